>>> rtl/smpa_pkg.sv
// package: constants, types and helper functions for the symbolic mode parser
package smpa_pkg;

    localparam int MaxOpsDefault = 64;
    localparam int EntryW = 19;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_CHAR  = 2'd1,
        REQ_END   = 2'd2,
        REQ_APPLY = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        PH_LEAD  = 4'd0,
        PH_WHO   = 4'd1,
        PH_PREOP = 4'd2,
        PH_RHS   = 4'd3,
        PH_OCT   = 4'd4,
        PH_COPY  = 4'd5,
        PH_LET   = 4'd6,
        PH_TAIL  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_SUB  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        cond_x;
        logic        copy;
        logic [1:0]  op;
        logic [2:0]  who;
        logic [11:0] mask;
    } entry_t;

    function automatic logic [11:0] class_bits(input logic [2:0] who);
        class_bits = (who[0] ? 12'o4700 : 12'o0) | (who[1] ? 12'o2070 : 12'o0)
                   | (who[2] ? 12'o1007 : 12'o0);
    endfunction

    function automatic logic [11:0] apply_entry(input entry_t e, input logic [11:0] m,
                                                input logic xcond);
        logic [2:0]  rwx;
        logic [11:0] target;
        logic [11:0] clr;
        logic [11:0] res;
        if (e.copy) begin
            rwx = e.mask[0] ? m[8:6] : (e.mask[1] ? m[5:3] : m[2:0]);
            target = {3'b0, (e.who[0] ? rwx : 3'b0), (e.who[1] ? rwx : 3'b0),
                      (e.who[2] ? rwx : 3'b0)};
            clr = class_bits(e.who) & 12'o0777;
        end else begin
            target = e.mask;
            if (e.cond_x && xcond) begin
                target = target | (class_bits(e.who) & 12'o0111);
            end
            clr = class_bits(e.who);
        end
        case (e.op)
            OP_SET:  res = (m & ~clr) | target;
            OP_ADD:  res = m | target;
            OP_SUB:  res = m & ~target;
            default: res = m;
        endcase
        apply_entry = res;
    endfunction

endpackage

>>> rtl/symbolic_mode_parse_apply_unit.sv
// top level: symbolic mode parser with a chain of operation cells
//
// Input channel s_*: one item per request (begin, character, end, apply).
// Begin and character items produce no result; end and apply items produce
// one result on m_* (result_mode, parse_status, op_total).
// An end result, or an apply result with no valid set, is on m_* the cycle
// after the item is taken.
// An apply item with a valid set circulates the stored operations around the
// cell chain: the mode passes the tail cell once per cycle as the entries
// rotate, so its result appears once every entry has passed the tail cell,
// whatever number of operations is stored. The input is held off meanwhile,
// so a new item is not taken while an apply is in work.
// Entries are pushed into the head of the chain as clauses complete; the
// oldest entry sits deepest in the chain.
// One item is in work at a time. The result sits in an output register; while
// it waits and m_ready is low the input is held off, and a new item is taken
// in the cycle the waiting result is taken.
// Reset (aresetn low, synchronous) clears the parser to an empty set and the
// result register to empty; the cell contents need no reset.
module symbolic_mode_parse_apply_unit #(
    parameter int MaxOps = smpa_pkg::MaxOpsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_char_code,
    input  logic [11:0] s_base_mode,
    input  logic        s_is_directory,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_result_mode,
    output logic [1:0]  m_parse_status,
    output logic [6:0]  m_op_total
);
    import smpa_pkg::*;

    localparam int CntW = $clog2(MaxOps + 1);
    localparam int IdxW = (MaxOps > 1) ? $clog2(MaxOps) : 1;

    logic            acc;
    logic            push;
    entry_t          push_entry;
    logic [CntW-1:0] op_count;
    logic [CntW-1:0] op_count_next;
    logic            set_valid;
    logic [1:0]      error_code;
    logic [1:0]      error_code_next;

    logic            busy_reg, busy_next;
    logic [IdxW-1:0] step_reg, step_next;
    logic [11:0]     mode_reg, mode_next;
    logic            xcond_reg;
    logic            out_valid_reg, out_valid_next;
    logic [11:0]     out_mode_reg;
    logic [1:0]      out_st_reg;
    logic [6:0]      out_tot_reg;

    entry_t      ent [MaxOps];
    logic [11:0] tail_mode;
    logic        rot;
    logic        tail_active;
    logic        finish;

    assign s_ready = !busy_reg && (!out_valid_reg || m_ready);
    assign acc     = s_valid && s_ready;

    smpa_parser #(.MaxOps(MaxOps), .CntW(CntW)) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .begin_req       (acc && s_req_type == REQ_BEGIN),
        .char_req        (acc && s_req_type == REQ_CHAR),
        .end_req         (acc && s_req_type == REQ_END),
        .char_code       (s_char_code),
        .push            (push),
        .push_entry      (push_entry),
        .op_count        (op_count),
        .op_count_next   (op_count_next),
        .set_valid       (set_valid),
        .error_code      (error_code),
        .error_code_next (error_code_next)
    );

    // during apply the chain rotates: tail entry returns to head each cycle
    assign rot = busy_reg;
    // stored entries reach the tail in the last op_count rotation steps, oldest first
    assign tail_active = (32'(step_reg) + 32'(op_count) >= MaxOps);

    genvar i;
    generate
        for (i = 0; i < MaxOps; i++) begin : g_cell
            logic [11:0] mo;
            smpa_cell u_cell (
                .aclk       (aclk),
                .load       (i == 0 ? (push || rot) : 1'b0),
                .load_entry (push ? push_entry : ent[MaxOps-1]),
                .shift      (push || rot),
                .prev_entry (i == 0 ? push_entry : ent[(i == 0) ? 0 : i-1]),
                .entry      (ent[i]),
                .mode_in    (mode_reg),
                .xcond      (xcond_reg),
                .active     (tail_active),
                .mode_out   (mo)
            );
            if (i == MaxOps - 1) begin : g_tail
                assign tail_mode = mo;
            end
        end
    endgenerate

    assign finish = busy_reg && (32'(step_reg) == MaxOps - 1);

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        mode_next = mode_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if (acc && s_req_type == REQ_APPLY && set_valid) begin
            busy_next = 1'b1;
            step_next = '0;
            mode_next = s_base_mode;
        end else if (busy_reg) begin
            mode_next = tail_mode;
            step_next = step_reg + 1'b1;
            if (finish) begin
                busy_next = 1'b0;
                out_valid_next = 1'b1;
            end
        end
        if (acc && (s_req_type == REQ_END || (s_req_type == REQ_APPLY && !set_valid))) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
        step_reg <= step_next;
        mode_reg <= mode_next;
        if (acc && s_req_type == REQ_APPLY) begin
            xcond_reg <= s_is_directory || (s_base_mode & 12'o0111) != 12'o0;
        end
        if (finish) begin
            out_mode_reg <= tail_mode;
        end else if (acc && s_req_type == REQ_END) begin
            out_mode_reg <= '0;
        end else if (acc && s_req_type == REQ_APPLY) begin
            out_mode_reg <= s_base_mode;
        end
        if (acc && (s_req_type == REQ_END || s_req_type == REQ_APPLY)) begin
            out_st_reg  <= error_code_next;
            out_tot_reg <= 7'(op_count_next);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_mode  = out_mode_reg;
    assign m_parse_status = out_st_reg;
    assign m_op_total     = out_tot_reg;
endmodule

>>> rtl/smpa_cell.sv
// one storage cell of the operation chain: holds an entry and applies it to passing mode
module smpa_cell (
    input  logic                  aclk,
    input  logic                  load,
    input  smpa_pkg::entry_t      load_entry,
    input  logic                  shift,
    input  smpa_pkg::entry_t      prev_entry,
    output smpa_pkg::entry_t      entry,
    input  logic [11:0]           mode_in,
    input  logic                  xcond,
    input  logic                  active,
    output logic [11:0]           mode_out
);
    import smpa_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= load_entry;
        end else if (shift) begin
            entry_reg <= prev_entry;
        end
    end

    assign entry    = entry_reg;
    assign mode_out = active ? apply_entry(entry_reg, mode_in, xcond) : mode_in;
endmodule

>>> rtl/smpa_parser.sv
// character parser: turns the mode string into operation entries
module smpa_parser #(
    parameter int MaxOps = smpa_pkg::MaxOpsDefault,
    parameter int CntW   = $clog2(MaxOps + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   begin_req,
    input  logic                   char_req,
    input  logic                   end_req,
    input  logic [7:0]             char_code,
    output logic                   push,
    output smpa_pkg::entry_t       push_entry,
    output logic [CntW-1:0]        op_count,
    output logic [CntW-1:0]        op_count_next,
    output logic                   set_valid,
    output logic [1:0]             error_code,
    output logic [1:0]             error_code_next
);
    import smpa_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            valid_reg, valid_next;
    logic [1:0]      err_reg, err_next;
    logic [2:0]      who_reg, who_next;
    logic [1:0]      oper_reg, oper_next;
    logic [11:0]     acc_reg, acc_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            cx_reg, cx_next;

    logic       blank, digit, is_letter, is_copyc;
    logic [2:0] w;
    logic [1:0] opc;
    logic [11:0] lbits;
    logic       commit_req, commit_copy, full, tail_go;
    entry_t     e;

    always_comb begin
        blank = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
        digit = (char_code >= "0") && (char_code <= "7");
        case (char_code)
            "u":     w = 3'd1;
            "g":     w = 3'd2;
            "o":     w = 3'd4;
            "a":     w = 3'd7;
            default: w = 3'd0;
        endcase
        case (char_code)
            "=":     opc = OP_SET;
            "+":     opc = OP_ADD;
            "-":     opc = OP_SUB;
            default: opc = OP_NONE;
        endcase
        is_copyc  = (char_code == "u") || (char_code == "g") || (char_code == "o");
        is_letter = 1'b1;
        case (char_code)
            "r":     lbits = 12'o0444;
            "w":     lbits = 12'o0222;
            "x":     lbits = 12'o0111;
            "X":     lbits = 12'o0;
            "s":     lbits = 12'o6000;
            "t":     lbits = 12'o1000;
            default: begin
                lbits = 12'o0;
                is_letter = 1'b0;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        err_next   = err_reg;
        who_next   = who_reg;
        oper_next  = oper_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        cx_next    = cx_reg;
        commit_req  = 1'b0;
        commit_copy = 1'b0;
        tail_go     = 1'b0;
        push        = 1'b0;
        full = (32'(count_reg) >= MaxOps);
        e.copy   = 1'b0;
        e.cond_x = cx_reg;
        e.op     = oper_reg;
        e.who    = who_reg;
        e.mask   = acc_reg & class_bits(who_reg);

        if (begin_req) begin
            phase_next = PH_LEAD;
            count_next = '0;
            valid_next = 1'b0;
            err_next   = ST_OK;
            who_next   = '0;
            oper_next  = OP_NONE;
            acc_next   = '0;
            cnt_next   = '0;
            cx_next    = 1'b0;
        end else if (char_req && err_reg == ST_OK) begin
            case (phase_reg)
                PH_LEAD: begin
                    if (blank || char_code == ",") begin
                    end else if (w != 3'd0) begin
                        who_next = w;
                        phase_next = PH_WHO;
                    end else if (opc != OP_NONE) begin
                        who_next = 3'd7;
                        oper_next = opc;
                        acc_next = '0;
                        cnt_next = '0;
                        cx_next = 1'b0;
                        phase_next = PH_RHS;
                    end else begin
                        err_next = ST_BAD;
                        valid_next = 1'b0;
                    end
                end
                PH_WHO, PH_PREOP: begin
                    if (w != 3'd0 && phase_reg == PH_WHO) begin
                        who_next = who_reg | w;
                    end else if (blank) begin
                        phase_next = PH_PREOP;
                    end else if (opc != OP_NONE) begin
                        oper_next = opc;
                        acc_next = '0;
                        cnt_next = '0;
                        cx_next = 1'b0;
                        phase_next = PH_RHS;
                    end else begin
                        err_next = ST_BAD;
                        valid_next = 1'b0;
                    end
                end
                PH_RHS: begin
                    if (blank) begin
                    end else if (digit) begin
                        acc_next = {9'd0, char_code[2:0]};
                        cnt_next = 3'd1;
                        phase_next = PH_OCT;
                    end else if (is_copyc) begin
                        acc_next = {9'd0, w};
                        phase_next = PH_COPY;
                    end else if (is_letter) begin
                        acc_next = acc_reg | lbits;
                        if (char_code == "X") cx_next = 1'b1;
                        phase_next = PH_LET;
                    end else begin
                        err_next = ST_BAD;
                        valid_next = 1'b0;
                    end
                end
                PH_OCT: begin
                    if (digit && cnt_reg < 3'd4) begin
                        acc_next = {acc_reg[8:0], char_code[2:0]};
                        cnt_next = cnt_reg + 3'd1;
                    end else begin
                        commit_req = 1'b1;
                        tail_go = 1'b1;
                    end
                end
                PH_COPY: begin
                    if (blank || char_code == ",") begin
                        commit_req = 1'b1;
                        commit_copy = 1'b1;
                        tail_go = 1'b1;
                    end else begin
                        err_next = ST_BAD;
                        valid_next = 1'b0;
                    end
                end
                PH_LET: begin
                    if (is_letter) begin
                        acc_next = acc_reg | lbits;
                        if (char_code == "X") cx_next = 1'b1;
                    end else if (blank || char_code == ",") begin
                        commit_req = 1'b1;
                        tail_go = 1'b1;
                    end else begin
                        err_next = ST_BAD;
                        valid_next = 1'b0;
                    end
                end
                PH_TAIL: tail_go = 1'b1;
                default: begin
                end
            endcase
        end else if (end_req && phase_reg != PH_DONE) begin
            if (err_reg == ST_OK) begin
                case (phase_reg)
                    PH_WHO, PH_PREOP, PH_RHS: err_next = ST_BAD;
                    PH_OCT, PH_LET: commit_req = 1'b1;
                    PH_COPY: begin
                        commit_req = 1'b1;
                        commit_copy = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            phase_next = PH_DONE;
        end

        if (commit_copy) begin
            e.copy   = 1'b1;
            e.cond_x = 1'b0;
            e.mask   = {9'd0, acc_reg[2:0]};
        end

        if (commit_req) begin
            if (full) begin
                err_next = ST_FULL;
                valid_next = 1'b0;
                tail_go = 1'b0;
            end else begin
                push = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end

        if (tail_go) begin
            if (blank) begin
                phase_next = PH_TAIL;
            end else if (char_code == ",") begin
                phase_next = PH_LEAD;
            end else begin
                err_next = ST_BAD;
                valid_next = 1'b0;
            end
        end

        if (end_req && phase_reg != PH_DONE) begin
            valid_next = (err_next == ST_OK);
        end
    end

    assign push_entry      = e;
    assign op_count        = count_reg;
    assign op_count_next   = count_next;
    assign set_valid       = valid_reg;
    assign error_code      = err_reg;
    assign error_code_next = err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            valid_reg <= 1'b0;
            err_reg   <= ST_OK;
            who_reg   <= '0;
            oper_reg  <= OP_NONE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            cx_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            err_reg   <= err_next;
            who_reg   <= who_next;
            oper_reg  <= oper_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            cx_reg    <= cx_next;
        end
    end
endmodule
